>>> src/lpfr_pkg.sv
// shared types, constants and helpers for the length prefixed frame receiver
// no dependencies
package lpfr_pkg;

   localparam int LENGTH_BITS_DEF = 23;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int HEADER_BYTES    = 8;

   localparam logic [31:0] MAGIC_RESET    = 32'hF150_CCC2;
   localparam logic [23:0] MAX_SIZE_RESET = 24'h80_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAGIC      = 2'd0,
      CSR_MAX_SIZE   = 2'd1,
      CSR_BIG_ENDIAN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD   = 1'b0,
      KIND_MALFORMED = 1'b1
   } kind_type;

   typedef struct packed {
      logic [31:0] magic;
      logic [23:0] max_size;
      logic        big_endian;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

>>> src/length_prefixed_frame_receiver_top.sv
// length prefixed frame receiver: one byte per word in, payload bytes and malformed marks out
// a result word is registered and is valid in the cycle after the byte that causes it is taken
// throughput: one byte per cycle while the result channel does not stall, set by the single result register
// reset: synchronous, active high; clears control and configuration registers to defaults, expects a header
// depends on lpfr_pkg, lpfr_csr, lpfr_parser, lpfr_out_reg
module length_prefixed_frame_receiver_top #(
   parameter int LENGTH_BITS = lpfr_pkg::LENGTH_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_frame_last,
   input  logic                             csr_we,
   input  logic [lpfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lpfr_pkg::cfg_type    cfg;
   lpfr_pkg::result_type res;
   lpfr_pkg::result_type out_data;
   logic                 res_valid;
   logic                 step;

   assign step = req_valid && req_ready;

   lpfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpfr_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_ready (rsp_ready)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_payload_byte = out_data.data;
   assign rsp_frame_last   = out_data.last;

endmodule

>>> src/lpfr_csr.sv
// configuration registers: magic word, size limit and header byte order
// depends on lpfr_pkg
module lpfr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lpfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output lpfr_pkg::cfg_type                 cfg
);

   lpfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lpfr_pkg::CSR_MAGIC:      cfg_in.magic      = csr_wdata[31:0];
            lpfr_pkg::CSR_MAX_SIZE:   cfg_in.max_size   = csr_wdata[23:0];
            lpfr_pkg::CSR_BIG_ENDIAN: cfg_in.big_endian = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic      <= lpfr_pkg::MAGIC_RESET;
         cfg_ff.max_size   <= lpfr_pkg::MAX_SIZE_RESET;
         cfg_ff.big_endian <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/lpfr_parser.sv
// frame parser: header collection and check, payload count, sticky error
// depends on lpfr_pkg
module lpfr_parser #(
   parameter int LENGTH_BITS = lpfr_pkg::LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  lpfr_pkg::cfg_type      cfg,
   output logic                   res_valid,
   output lpfr_pkg::result_type   res
);

   localparam logic [32:0] LenLimit = 33'((64'd1 << LENGTH_BITS) + 64'd7);

   lpfr_pkg::phase_type    phase_ff, phase_in;
   logic [55:0]            hdr_ff, hdr_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;

   logic [63:0] full;
   logic [31:0] magic;
   logic [31:0] size;
   logic [31:0] payload_len;
   logic        bad;

   always_comb begin
      full        = {hdr_ff, rx_byte};
      magic       = cfg.big_endian ? full[63:32] : lpfr_pkg::swap32(full[63:32]);
      size        = cfg.big_endian ? full[31:0]  : lpfr_pkg::swap32(full[31:0]);
      payload_len = size - 32'(lpfr_pkg::HEADER_BYTES);
      bad         = (magic != cfg.magic)
                 || (size <= 32'(lpfr_pkg::HEADER_BYTES))
                 || (size > {8'd0, cfg.max_size})
                 || ({1'b0, size} > LenLimit);
   end

   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      res_valid = 1'b0;
      res.kind  = lpfr_pkg::KIND_PAYLOAD;
      res.data  = 8'd0;
      res.last  = 1'b0;
      if (step) begin
         unique case (phase_ff)
            lpfr_pkg::PH_HEADER: begin
               hdr_in = full[55:0];
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  if (bad) begin
                     phase_in  = lpfr_pkg::PH_ERROR;
                     res_valid = 1'b1;
                     res.kind  = lpfr_pkg::KIND_MALFORMED;
                  end else begin
                     phase_in = lpfr_pkg::PH_PAYLOAD;
                     rem_in   = payload_len[LENGTH_BITS-1:0];
                  end
               end
            end
            lpfr_pkg::PH_PAYLOAD: begin
               rem_in    = rem_ff - LENGTH_BITS'(1);
               res_valid = 1'b1;
               res.data  = rx_byte;
               if (rem_ff == LENGTH_BITS'(1)) begin
                  res.last = 1'b1;
                  phase_in = lpfr_pkg::PH_HEADER;
                  cnt_in   = 3'd0;
               end
            end
            default: begin
               res_valid = 1'b1;
               res.kind  = lpfr_pkg::KIND_MALFORMED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lpfr_pkg::PH_HEADER;
         cnt_ff   <= 3'd0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

>>> src/lpfr_out_reg.sv
// result register between the parser and the result channel
// depends on lpfr_pkg
module lpfr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  lpfr_pkg::result_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output lpfr_pkg::result_type out_data,
   input  logic                 out_ready
);

   logic                 valid_ff, valid_in;
   lpfr_pkg::result_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/lpfr_checker.sv
// port level checks for the length prefixed frame receiver, bound to the top level
// depends on lpfr_pkg and length_prefixed_frame_receiver_top
module lpfr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_kind,
   input logic [7:0]                       rsp_payload_byte,
   input logic                             rsp_frame_last
);

   logic err_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_kind == lpfr_pkg::KIND_MALFORMED) begin
         err_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_frame_last))
      else $error("result word changed while stalled");

   a_malformed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lpfr_pkg::KIND_MALFORMED
         |-> rsp_payload_byte == 8'd0 && !rsp_frame_last)
      else $error("malformed word carries data");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |-> rsp_kind == lpfr_pkg::KIND_MALFORMED)
      else $error("payload word after stream error");

   a_ready_only_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (.*);
